[design/divider_64bit_signed_unsigned_core_assert.svh]
// assertion macros shared by the divider checker
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_CORE_ASSERT_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define D64_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define D64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/div64su_pkg.sv]
package div64su_pkg;

	// operand width and number of quotient steps
	localparam int DATA_WIDTH = 64;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// payload handed from one division cell to the next
	typedef struct packed {
		logic  flip;   // quotient is negated at the end
		logic  zero;   // divisor was zero
		word_t part;   // partial remainder
		word_t nq;     // dividend bits still to come, quotient bits shifted in
		word_t den;    // divisor magnitude
	} step_t;

endpackage

[design/divider_64bit_signed_unsigned_core.sv]
// Pipelined 64-bit divider, unsigned (action 0) or signed two's complement
// (action 1). One transfer is taken per clock while req_stall is low: a first
// register holds the operand magnitudes, a row of 64 identical subtract cells
// produces one quotient bit each, and an output register holds the result with
// the quotient sign applied. Signed division divides magnitudes; the
// remainder is the remainder of the magnitudes. A zero divisor gives quotient
// 0 and remainder equal to the dividend magnitude. The whole row advances
// together, so req_stall rises only while a result waits and rsp_stall is high.
module divider_64bit_signed_unsigned_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                action,
	input  div64su_pkg::word_t  dividend,
	input  div64su_pkg::word_t  divisor,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output div64su_pkg::word_t  quotient,
	output div64su_pkg::word_t  remainder
);

	localparam int W = div64su_pkg::DATA_WIDTH;

	logic                en;
	logic                num_neg;
	logic                den_neg;
	div64su_pkg::step_t  start;
	logic                valid_s1;
	div64su_pkg::step_t  data_s1;
	logic [W:0]          chain_valid;
	div64su_pkg::step_t  chain_data [W+1];
	div64su_pkg::step_t  last;
	div64su_pkg::word_t  quo_final;
	logic                valid_s2;
	div64su_pkg::word_t  quo_s2;
	div64su_pkg::word_t  rem_s2;

	// whole pipeline moves unless a result is held by the consumer
	assign en        = !valid_s2 || !rsp_stall;
	assign req_stall = !en;

	// operand magnitudes and quotient sign
	always_comb begin
		num_neg    = action & dividend[W-1];
		den_neg    = action & divisor[W-1];
		start.flip = num_neg ^ den_neg;
		start.zero = (divisor == '0);
		start.part = '0;
		start.nq   = num_neg ? (~dividend + div64su_pkg::word_t'(1)) : dividend;
		start.den  = den_neg ? (~divisor + div64su_pkg::word_t'(1)) : divisor;
	end

	// first stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= start;
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_data[0]  = data_s1;

	// row of subtract cells, one quotient bit per cell
	for (genvar i = 0; i < W; i++) begin : g_cell
		div64su_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (chain_valid[i]),
			.prev       (chain_data[i]),
			.cur_valid  (chain_valid[i+1]),
			.cur        (chain_data[i+1])
		);
	end

	// quotient sign and zero-divisor override
	always_comb begin
		last = chain_data[W];
		if (last.zero) begin
			quo_final = '0;
		end else if (last.flip) begin
			quo_final = ~last.nq + div64su_pkg::word_t'(1);
		end else begin
			quo_final = last.nq;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= chain_valid[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= quo_final;
			rem_s2 <= last.part;
		end
	end

	assign rsp_valid = valid_s2;
	assign quotient  = quo_s2;
	assign remainder = rem_s2;

endmodule

[design/div64su_cell.sv]
module div64su_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                prev_valid,
	input  div64su_pkg::step_t  prev,
	output logic                cur_valid,
	output div64su_pkg::step_t  cur
);

	localparam int W = div64su_pkg::DATA_WIDTH;

	logic               cell_valid_q;
	div64su_pkg::step_t cell_data_q;
	div64su_pkg::step_t nxt;
	logic               carry;
	logic [W-1:0]       shifted;
	logic [W:0]         diff;
	logic               take;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		carry   = prev.part[W-1];
		shifted = {prev.part[W-2:0], prev.nq[W-1]};
		diff    = {carry, shifted} - {1'b0, prev.den};
		take    = carry | ~diff[W];
		nxt      = prev;
		nxt.part = take ? diff[W-1:0] : shifted;
		nxt.nq   = {prev.nq[W-2:0], take};
	end

	// valid bit of this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
		end else if (en) begin
			cell_valid_q <= prev_valid;
		end
	end

	// payload of this cell
	always_ff @(posedge clk) begin
		if (en) begin
			cell_data_q <= nxt;
		end
	end

	assign cur_valid = cell_valid_q;
	assign cur       = cell_data_q;

endmodule

[design/div64su_checker.sv]
`include "divider_64bit_signed_unsigned_core_assert.svh"

module div64su_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input div64su_pkg::word_t  quotient,
	input div64su_pkg::word_t  remainder
);

	// a held result stays offered
	`D64_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

	// a held result keeps its value
	`D64_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(quotient) && $stable(remainder), "result changed while stalled")

	// requests are only held back by a waiting result
	`D64_ASSERT_SAME(a_req_stall, req_stall, rsp_valid && rsp_stall, "request stalled without back pressure")

endmodule

bind divider_64bit_signed_unsigned_core div64su_checker u_checker (.*);
